@@ hdl/pqr_pkg.sv @@
// Shared types, codes and key compare for the priority queue with change-priority.
package pqr_pkg;

  localparam int OP_W  = 2;
  localparam int ID_W  = 16;
  localparam int PRI_W = 16;
  localparam int TIM_W = 16;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  // Operation codes of a command word
  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CHG = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  // Status codes of a result word
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // One task as held in a cell
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [PRI_W-1:0] pri;
    logic [TIM_W-1:0]        tim;
  } entry_t;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2,
    CM_POP    = 2'd3
  } cell_mode_t;

  // Strictly larger by priority (signed), then by id (unsigned)
  function automatic logic key_above(entry_t a, entry_t b);
    logic res;
    if (a.pri != b.pri) begin
      res = (a.pri > b.pri);
    end else begin
      res = (a.id > b.id);
    end
    return res;
  endfunction

  function automatic logic key_equal(entry_t a, entry_t b);
    return (a.pri == b.pri) && (a.id == b.id);
  endfunction

endpackage

@@ hdl/pqr_if.sv @@
// Valid/ready channel interfaces for command words and result words.
interface pqr_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [pqr_pkg::OP_W-1:0]         op;
  logic [pqr_pkg::ID_W-1:0]         task_id;
  logic signed [pqr_pkg::PRI_W-1:0] task_priority;
  logic [pqr_pkg::TIM_W-1:0]        task_time;

  modport source (output valid, output op, output task_id, output task_priority,
                  output task_time, input ready);
  modport sink   (input valid, input op, input task_id, input task_priority,
                  input task_time, output ready);
endinterface

interface pqr_res_if;
  logic                             valid;
  logic                             ready;
  logic [pqr_pkg::ST_W-1:0]         status;
  logic [pqr_pkg::ID_W-1:0]         out_id;
  logic signed [pqr_pkg::PRI_W-1:0] out_priority;
  logic [pqr_pkg::TIM_W-1:0]        out_time;
  logic [pqr_pkg::OCC_W-1:0]        occupancy;

  modport source (output valid, output status, output out_id, output out_priority,
                  output out_time, output occupancy, input ready);
  modport sink   (input valid, input status, input out_id, input out_priority,
                  input out_time, input occupancy, output ready);
endinterface

@@ hdl/pqr_cell.sv @@
// One cell of the sorted chain: a task, its age rank and a search token stage.
module pqr_cell #(
  parameter int AW = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  pqr_pkg::cell_mode_t mode,
  input  pqr_pkg::entry_t     bc_entry,
  input  logic [AW-1:0]       bc_age,
  input  logic                left_valid,
  input  logic                left_above,
  input  pqr_pkg::entry_t     left_entry,
  input  logic [AW-1:0]       left_age,
  input  logic                right_valid,
  input  pqr_pkg::entry_t     right_entry,
  input  logic [AW-1:0]       right_age,
  input  logic                tin_found,
  input  logic [AW-1:0]       tin_age,
  input  pqr_pkg::entry_t     tin_entry,
  output logic                valid,
  output pqr_pkg::entry_t     entry,
  output logic [AW-1:0]       age,
  output logic                above,
  output logic                tok_found,
  output logic [AW-1:0]       tok_age,
  output pqr_pkg::entry_t     tok_entry
);

  logic            valid_next;
  pqr_pkg::entry_t entry_next;
  logic [AW-1:0]   age_next;
  logic            hit;

  // Full order: key, then older first; this cell sits strictly ahead of the broadcast
  assign above = valid && (pqr_pkg::key_above(entry, bc_entry) ||
                 (pqr_pkg::key_equal(entry, bc_entry) && (age < bc_age)));

  // Search token: keeps the oldest matching id seen so far along the chain
  assign hit = valid && (entry.id == bc_entry.id) && (!tin_found || (age < tin_age));

  // Cell update
  always_comb begin
    valid_next = valid;
    entry_next = entry;
    age_next   = age;
    unique case (mode)
      pqr_pkg::CM_HOLD: begin
      end
      pqr_pkg::CM_INSERT: begin
        if (!above) begin
          if (left_above) begin
            valid_next = 1'b1;
            entry_next = bc_entry;
            age_next   = bc_age;
          end else begin
            valid_next = left_valid;
            entry_next = left_entry;
            age_next   = left_age;
          end
        end
      end
      pqr_pkg::CM_REMOVE: begin
        if (!above) begin
          valid_next = right_valid;
          entry_next = right_entry;
          age_next   = right_age;
        end
      end
      pqr_pkg::CM_POP: begin
        // head leaves; ranks younger than it close the gap
        valid_next = right_valid;
        entry_next = right_entry;
        if (right_age > bc_age) begin
          age_next = right_age - AW'(1);
        end else begin
          age_next = right_age;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      tok_found <= 1'b0;
    end else begin
      valid     <= valid_next;
      tok_found <= hit || tin_found;
    end
    entry <= entry_next;
    age   <= age_next;
    if (hit) begin
      tok_age   <= age;
      tok_entry <= entry;
    end else begin
      tok_age   <= tin_age;
      tok_entry <= tin_entry;
    end
  end

endmodule

@@ hdl/priority_queue_with_rekey.sv @@
// Top level: max priority queue with change-priority, built on a sorted chain of cells.
//
//   channel  dir  handshake          payload
//   cmd      in   valid/ready        op, task_id, task_priority, task_time
//   res      out  valid/ready        status, out_id, out_priority, out_time, occupancy
//
// Enqueue, dequeue and the unused op are accepted, then one chain update also loads
// the result register. Change priority sends a search token along the whole chain
// one cell per cycle; when the id is held, the entry is then pulled out and
// reinserted with its new priority, and when it is not, the result loads right after
// the walk. A command is taken while the previous result still waits; the chain
// update that loads the result waits until the result register is free.
// Synchronous reset empties the chain.
module priority_queue_with_rekey #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  pqr_cmd_if.sink   cmd,
  pqr_res_if.source res
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int LAST = CAPACITY - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_DECIDE,
    S_REINS
  } state_t;

  state_t                          state;
  pqr_pkg::op_t                    it_op;
  logic [pqr_pkg::ID_W-1:0]        it_id;
  logic signed [pqr_pkg::PRI_W-1:0] it_pri;
  logic [pqr_pkg::TIM_W-1:0]       it_tim;
  logic [CW-1:0]                   count;
  logic [CW-1:0]                   cnt_next;
  logic [AW-1:0]                   srch;
  logic [AW-1:0]                   sv_age;
  logic [pqr_pkg::TIM_W-1:0]       sv_tim;

  pqr_pkg::cell_mode_t mode;
  pqr_pkg::entry_t     bc_entry;
  logic [AW-1:0]       bc_age;
  logic                ld;
  pqr_pkg::status_t    ld_status;
  pqr_pkg::entry_t     ld_entry;
  logic                out_free;

  // chain taps
  logic            c_valid [CAPACITY];
  pqr_pkg::entry_t c_entry [CAPACITY];
  logic [AW-1:0]   c_age   [CAPACITY];
  logic            c_above [CAPACITY];
  logic            t_found [CAPACITY];
  logic [AW-1:0]   t_age   [CAPACITY];
  pqr_pkg::entry_t t_entry [CAPACITY];

  assign cmd.ready = (state == S_IDLE);
  assign out_free  = !res.valid || res.ready;

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            l_valid;
    logic            l_above;
    pqr_pkg::entry_t l_entry;
    logic [AW-1:0]   l_age;
    logic            r_valid;
    pqr_pkg::entry_t r_entry;
    logic [AW-1:0]   r_age;
    logic            ti_found;
    logic [AW-1:0]   ti_age;
    pqr_pkg::entry_t ti_entry;

    if (i == 0) begin : g_head
      assign l_valid  = 1'b0;
      assign l_above  = 1'b1;
      assign l_entry  = '0;
      assign l_age    = '0;
      assign ti_found = 1'b0;
      assign ti_age   = '0;
      assign ti_entry = '0;
    end else begin : g_link
      assign l_valid  = c_valid[i-1];
      assign l_above  = c_above[i-1];
      assign l_entry  = c_entry[i-1];
      assign l_age    = c_age[i-1];
      assign ti_found = t_found[i-1];
      assign ti_age   = t_age[i-1];
      assign ti_entry = t_entry[i-1];
    end

    if (i == LAST) begin : g_tail
      assign r_valid = 1'b0;
      assign r_entry = '0;
      assign r_age   = '0;
    end else begin : g_next
      assign r_valid = c_valid[i+1];
      assign r_entry = c_entry[i+1];
      assign r_age   = c_age[i+1];
    end

    pqr_cell #(.AW(AW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .mode        (mode),
      .bc_entry    (bc_entry),
      .bc_age      (bc_age),
      .left_valid  (l_valid),
      .left_above  (l_above),
      .left_entry  (l_entry),
      .left_age    (l_age),
      .right_valid (r_valid),
      .right_entry (r_entry),
      .right_age   (r_age),
      .tin_found   (ti_found),
      .tin_age     (ti_age),
      .tin_entry   (ti_entry),
      .valid       (c_valid[i]),
      .entry       (c_entry[i]),
      .age         (c_age[i]),
      .above       (c_above[i]),
      .tok_found   (t_found[i]),
      .tok_age     (t_age[i]),
      .tok_entry   (t_entry[i])
    );
  end

  // Chain command, broadcast word and result load
  always_comb begin
    mode      = pqr_pkg::CM_HOLD;
    bc_entry  = '{id: it_id, pri: it_pri, tim: it_tim};
    bc_age    = AW'(count);
    ld        = 1'b0;
    ld_status = pqr_pkg::ST_OK;
    ld_entry  = '0;
    cnt_next  = count;
    unique case (state)
      S_EXEC: begin
        if (out_free && (it_op != pqr_pkg::OP_CHG)) begin
          ld = 1'b1;
          unique case (it_op)
            pqr_pkg::OP_ENQ: begin
              if (count == CW'(CAPACITY)) begin
                ld_status = pqr_pkg::ST_FULL;
              end else begin
                mode     = pqr_pkg::CM_INSERT;
                cnt_next = count + CW'(1);
              end
            end
            pqr_pkg::OP_DEQ: begin
              if (count == '0) begin
                ld_status = pqr_pkg::ST_EMPTY;
              end else begin
                mode     = pqr_pkg::CM_POP;
                bc_age   = c_age[0];
                ld_entry = c_entry[0];
                cnt_next = count - CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DECIDE: begin
        if (t_found[LAST]) begin
          mode     = pqr_pkg::CM_REMOVE;
          bc_entry = '{id: it_id, pri: t_entry[LAST].pri, tim: t_entry[LAST].tim};
          bc_age   = t_age[LAST];
        end else if (out_free) begin
          ld        = 1'b1;
          ld_status = pqr_pkg::ST_NOTFOUND;
        end
      end
      S_REINS: begin
        bc_entry = '{id: it_id, pri: it_pri, tim: sv_tim};
        bc_age   = sv_age;
        if (out_free) begin
          mode = pqr_pkg::CM_INSERT;
          ld   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, occupancy and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      srch      <= '0;
      res.valid <= 1'b0;
    end else begin
      count <= cnt_next;
      if (ld) begin
        res.valid        <= 1'b1;
        res.status       <= ld_status;
        res.out_id       <= ld_entry.id;
        res.out_priority <= ld_entry.pri;
        res.out_time     <= ld_entry.tim;
        res.occupancy    <= pqr_pkg::OCC_W'(cnt_next);
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            it_op  <= pqr_pkg::op_t'(cmd.op);
            it_id  <= cmd.task_id;
            it_pri <= cmd.task_priority;
            it_tim <= cmd.task_time;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (it_op == pqr_pkg::OP_CHG) begin
            srch  <= '0;
            state <= S_SEARCH;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SEARCH: begin
          // token advances one cell per cycle until it reaches the tail
          if (srch == AW'(LAST)) begin
            state <= S_DECIDE;
          end else begin
            srch <= srch + AW'(1);
          end
        end
        S_DECIDE: begin
          if (t_found[LAST]) begin
            sv_age <= t_age[LAST];
            sv_tim <= t_entry[LAST].tim;
            state  <= S_REINS;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_REINS: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sim/priority_queue_with_rekey_test.sv @@
// Testbench for priority_queue_with_rekey: directed and random commands against a predictor.

// Scoreboard: mirrors the task store in age order and holds the expected result words
class task_book;
  typedef struct packed {
    logic [pqr_pkg::ST_W-1:0]         status;
    logic [pqr_pkg::ID_W-1:0]         id;
    logic signed [pqr_pkg::PRI_W-1:0] pri;
    logic [pqr_pkg::TIM_W-1:0]        tim;
    logic [pqr_pkg::OCC_W-1:0]        occ;
  } outcome_t;

  pqr_pkg::entry_t held[$];     // oldest first
  outcome_t        awaited[$];  // expected result words, oldest first
  int              depth;
  int              errors;

  function new(int cap);
    depth  = cap;
    errors = 0;
  endfunction

  // Apply one accepted command to the mirror and queue its result word
  function void note_command(pqr_pkg::op_t op, logic [15:0] id, logic signed [15:0] pri,
                             logic [15:0] tim);
    outcome_t        want;
    pqr_pkg::entry_t task_in;
    int              best;
    want        = '0;
    want.status = pqr_pkg::ST_OK;
    case (op)
      pqr_pkg::OP_ENQ: begin
        if (held.size() >= depth) begin
          want.status = pqr_pkg::ST_FULL;
        end else begin
          task_in.id  = id;
          task_in.pri = pri;
          task_in.tim = tim;
          held.push_back(task_in);
        end
      end
      pqr_pkg::OP_DEQ: begin
        if (held.size() == 0) begin
          want.status = pqr_pkg::ST_EMPTY;
        end else begin
          // strictly larger wins, so an exact tie stays with the oldest
          best = 0;
          for (int i = 1; i < held.size(); i++) begin
            if ((held[i].pri > held[best].pri) ||
                (held[i].pri == held[best].pri && held[i].id > held[best].id)) begin
              best = i;
            end
          end
          want.id  = held[best].id;
          want.pri = held[best].pri;
          want.tim = held[best].tim;
          held.delete(best);
        end
      end
      pqr_pkg::OP_CHG: begin
        // oldest match gets the new priority and keeps its age
        want.status = pqr_pkg::ST_NOTFOUND;
        for (int i = 0; i < held.size(); i++) begin
          if (held[i].id == id) begin
            held[i].pri = pri;
            want.status = pqr_pkg::ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    want.occ = pqr_pkg::OCC_W'(held.size());
    awaited.push_back(want);
  endfunction

  function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Check one accepted result word against the oldest expectation
  function void check_result(logic [1:0] status, logic [15:0] id, logic signed [15:0] pri,
                             logic [15:0] tim, logic [4:0] occ);
    outcome_t want;
    if (awaited.size() == 0) begin
      $error("result word with no command pending");
      errors++;
      return;
    end
    want = awaited.pop_front();
    compare_field("status", 32'(want.status), 32'(status));
    compare_field("out_id", 32'(want.id), 32'(id));
    compare_field("out_priority", 32'(want.pri), 32'(pri));
    compare_field("out_time", 32'(want.tim), 32'(tim));
    compare_field("occupancy", 32'(want.occ), 32'(occ));
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module priority_queue_with_rekey_test;

  localparam int CAPACITY       = 16;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_WORDS    = 125;

  logic clk;
  logic rst;

  pqr_cmd_if cmd ();
  pqr_res_if res ();

  priority_queue_with_rekey #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd.sink),
    .res(res.source)
  );

  task_book book;
  int       idle_pct;
  int       stall_pct;
  logic     hold_toggle;
  logic     hold_seen;
  int       hold_left;
  int       quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: check accepted words, stall at random or for a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_seen = hold_toggle;
      hold_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        book.check_result(res.status, res.out_id, res.out_priority, res.out_time,
                          res.occupancy);
      end
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: too long without any word moving ends the run
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** priority_queue_with_rekey: FAILED **");
        $finish;
      end
    end
  end

  // Offer one command word, with random gaps, and record it once taken
  task automatic send_word(input pqr_pkg::op_t op, input logic [15:0] id,
                           input logic signed [15:0] pri, input logic [15:0] tim);
    while ($urandom_range(99) < idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid         <= 1'b1;
    cmd.op            <= op;
    cmd.task_id       <= id;
    cmd.task_priority <= pri;
    cmd.task_time     <= tim;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    book.note_command(op, id, pri, tim);
  endtask

  // Random command; filling leans toward enqueue, otherwise toward dequeue
  task automatic send_random(input bit filling);
    int                 held_n;
    int                 roll;
    pqr_pkg::op_t       op;
    logic [15:0]        id;
    logic signed [15:0] pri;
    held_n = book.held.size();
    roll   = $urandom_range(99);
    if (roll < 4) begin
      op = pqr_pkg::OP_NOP;
    end else if (roll < 26) begin
      op = pqr_pkg::OP_CHG;
    end else if (roll < (filling ? 82 : 44)) begin
      op = pqr_pkg::OP_ENQ;
    end else begin
      op = pqr_pkg::OP_DEQ;
    end
    // ids: often a held one or from a small pool, so matches and ties happen
    roll = $urandom_range(99);
    if (held_n > 0 && roll < 40) begin
      id = book.held[$urandom_range(held_n - 1)].id;
    end else if (roll < 75) begin
      id = 16'($urandom_range(7));
    end else begin
      id = 16'($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 45) begin
      pri = 16'($urandom_range(6) - 3);
    end else if (roll < 60) begin
      case ($urandom_range(3))
        0: pri = 16'h8000;
        1: pri = 16'h7FFF;
        2: pri = 16'hFFFF;
        default: pri = 16'h0000;
      endcase
    end else begin
      pri = 16'($urandom);
    end
    send_word(op, id, pri, 16'($urandom));
  endtask

  task automatic run_phase(input int words);
    bit filling;
    filling = 1'b1;
    for (int n = 0; n < words; n++) begin
      if (n % 30 == 29) filling = ~filling;
      send_random(filling);
    end
  endtask

  initial begin
    book              = new(CAPACITY);
    idle_pct          = 0;
    stall_pct         <= 0;
    hold_toggle       <= 1'b0;
    rst               <= 1'b1;
    cmd.valid         <= 1'b0;
    cmd.op            <= pqr_pkg::OP_NOP;
    cmd.task_id       <= '0;
    cmd.task_priority <= '0;
    cmd.task_time     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, unused op, field extremes, exact ties, full
    send_word(pqr_pkg::OP_DEQ, 16'h0000, 16'h0000, 16'h0000);
    send_word(pqr_pkg::OP_CHG, 16'h0005, 16'h0001, 16'h0000);
    send_word(pqr_pkg::OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(pqr_pkg::OP_ENQ, 16'h0000, 16'h8000, 16'h0000);
    send_word(pqr_pkg::OP_ENQ, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_word(pqr_pkg::OP_ENQ, 16'h1234, 16'h0005, 16'h0001);
    send_word(pqr_pkg::OP_ENQ, 16'h1234, 16'h0005, 16'h0002);
    send_word(pqr_pkg::OP_ENQ, 16'h1234, 16'h0005, 16'h0003);
    send_word(pqr_pkg::OP_ENQ, 16'h0001, 16'h7FFF, 16'h0007);
    send_word(pqr_pkg::OP_ENQ, 16'h8000, 16'hFFFF, 16'hAAAA);
    send_word(pqr_pkg::OP_ENQ, 16'h7FFF, 16'h0000, 16'h5555);
    for (int i = 0; i < 8; i++) begin
      send_word(pqr_pkg::OP_ENQ, 16'(100 + i), 16'((i % 3) - 1), 16'(i * 'h1111));
    end
    send_word(pqr_pkg::OP_ENQ, 16'h4321, 16'h0001, 16'h0001);
    send_word(pqr_pkg::OP_CHG, 16'h1234, 16'h7FFF, 16'h0000);
    send_word(pqr_pkg::OP_CHG, 16'hBEEF, 16'h0000, 16'h0000);
    repeat (3) send_word(pqr_pkg::OP_DEQ, 16'h0000, 16'h0000, 16'h0000);

    // Random phases under each idling pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 57; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 57; end
        default: begin idle_pct = 35; stall_pct <= 35; end
      endcase
      run_phase(PHASE_WORDS);
    end

    // Long receiver hold-off while commands keep coming
    idle_pct    = 0;
    stall_pct   <= 0;
    hold_toggle <= ~hold_toggle;
    run_phase(24);

    cmd.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (book.errors == 0) begin
      $display("** priority_queue_with_rekey: PASSED **");
    end else begin
      $display("** priority_queue_with_rekey: FAILED **");
    end
    $finish;
  end
endmodule
